// ===== src/ffba_pkg.sv =====
// Types and constants shared by the first-fit allocator modules.
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int unsigned HDR_W  = 7;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned ADDR_W = 16;
    localparam int unsigned TOP_W  = 17;
    localparam int unsigned SUM_W  = 18;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_OOM     = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [LEN_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] data_address;
    } t_req_word;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [1:0]        status;
    } t_res_word;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADVANCE,
        OP_SPLIT_NEW,
        OP_SPLIT_CUR,
        OP_ALLOC_CUR,
        OP_APPEND,
        OP_LINK,
        OP_FREE_CUR,
        OP_MERGE
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic       res_we;
        logic [1:0] res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic ignore;
        logic empty;
        logic fit;
        logic split_ok;
        logic last;
        logic append_ok;
        logic match;
        logic nx_free;
    } t_dp_stat;

endpackage

// ===== src/ffba_ctrl.sv =====
// Sequencing state machine of the first-fit allocator.
`timescale 1ns / 1ps
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output logic     o_strobe,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_SPLIT  = 8'b0000_1000,
        S_APPEND = 8'b0001_0000,
        S_LINK   = 8'b0010_0000,
        S_MERGE  = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state          = r_state;
        o_cmd.op         = OP_NONE;
        o_cmd.res_we     = 1'b0;
        o_cmd.res_status = ST_DONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.ignore) begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_IGNORED;
                    n_state          = S_RESP;
                end else if (i_stat.empty) begin
                    if (i_stat.is_free) begin
                        o_cmd.res_we     = 1'b1;
                        o_cmd.res_status = ST_UNKNOWN;
                        n_state          = S_RESP;
                    end else begin
                        n_state = S_APPEND;
                    end
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.is_free) begin
                    if (i_stat.fit) begin
                        if (i_stat.split_ok) begin
                            o_cmd.op = OP_SPLIT_NEW;
                            n_state  = S_SPLIT;
                        end else begin
                            o_cmd.op     = OP_ALLOC_CUR;
                            o_cmd.res_we = 1'b1;
                            n_state      = S_RESP;
                        end
                    end else if (i_stat.last) begin
                        n_state = S_APPEND;
                    end else begin
                        o_cmd.op = OP_ADVANCE;
                    end
                end else begin
                    if (i_stat.match) begin
                        o_cmd.op = OP_FREE_CUR;
                        if (i_stat.last) begin
                            o_cmd.res_we = 1'b1;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_MERGE;
                        end
                    end else if (i_stat.last) begin
                        o_cmd.res_we     = 1'b1;
                        o_cmd.res_status = ST_UNKNOWN;
                        n_state          = S_RESP;
                    end else begin
                        o_cmd.op = OP_ADVANCE;
                    end
                end
            end
            S_SPLIT: begin
                o_cmd.op     = OP_SPLIT_CUR;
                o_cmd.res_we = 1'b1;
                n_state      = S_RESP;
            end
            S_APPEND: begin
                if (i_stat.append_ok) begin
                    o_cmd.op = OP_APPEND;
                    if (i_stat.empty) begin
                        o_cmd.res_we = 1'b1;
                        n_state      = S_RESP;
                    end else begin
                        n_state = S_LINK;
                    end
                end else begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_OOM;
                    n_state          = S_RESP;
                end
            end
            S_LINK: begin
                o_cmd.op     = OP_LINK;
                o_cmd.res_we = 1'b1;
                n_state      = S_RESP;
            end
            S_MERGE: begin
                if (i_stat.nx_free) begin
                    o_cmd.op = OP_MERGE;
                end
                o_cmd.res_we = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_RESP);

endmodule

// ===== src/ffba_dpath.sv =====
// Block table, list registers and arithmetic of the first-fit allocator.
`timescale 1ns / 1ps
module ffba_dpath
    import ffba_pkg::*;
#(
    parameter int unsigned BLOCK_SLOTS = 32,
    parameter int unsigned ARENA_BYTES = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [HDR_W-1:0] i_cfg_data,
    input  t_req_word        i_item,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    output t_res_word        o_result
);

    localparam int unsigned IW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;

    // Block table, one array per field
    logic [ADDR_W-1:0] m_start [BLOCK_SLOTS];
    logic [LEN_W-1:0]  m_len   [BLOCK_SLOTS];
    logic              m_free  [BLOCK_SLOTS];
    logic [IW-1:0]     m_link  [BLOCK_SLOTS];

    logic [BLOCK_SLOTS-1:0] r_taken;
    logic [HDR_W-1:0]  r_hdr;
    logic [IW-1:0]     r_head, r_tail, r_cur, r_cnt, r_slot, r_aux, r_nx, r_spare;
    logic              r_empty, r_spare_ok;
    logic [TOP_W-1:0]  r_top;
    t_req_word         r_item;
    logic [LEN_W-1:0]  r_cur_len;
    logic [ADDR_W-1:0] r_grant, n_grant;
    t_res_word         r_res;

    logic [ADDR_W-1:0] r_rd_start;
    logic [LEN_W-1:0]  r_rd_len;
    logic              r_rd_free;
    logic [IW-1:0]     r_rd_link;
    logic [IW-1:0]     rd_addr;

    logic              w_en_start, w_en_len, w_en_free, w_en_link;
    logic [IW-1:0]     w_addr;
    logic [ADDR_W-1:0] w_start;
    logic [LEN_W-1:0]  w_len;
    logic              w_free;
    logic [IW-1:0]     w_link;

    logic [SUM_W-1:0]  data_sum, need_sum, split_start, top_need, merge_sum;
    logic [LEN_W-1:0]  merge_len;
    logic [IW-1:0]     spare_idx;
    logic              spare_any;

    // Header size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= HDR_W'(24);
        end else if (i_cfg_valid) begin
            r_hdr <= i_cfg_data;
        end
    end

    // Arithmetic on the entry under inspection
    assign data_sum    = SUM_W'(r_rd_start) + SUM_W'(r_hdr);
    assign need_sum    = SUM_W'(r_hdr) + SUM_W'(r_item.request_bytes);
    assign split_start = data_sum + SUM_W'(r_item.request_bytes);
    assign top_need    = SUM_W'(r_top) + need_sum;
    assign merge_sum   = SUM_W'(r_cur_len) + SUM_W'(r_hdr) + SUM_W'(r_rd_len);
    assign merge_len   = (merge_sum > SUM_W'(16'hFFFF)) ? 16'hFFFF : merge_sum[LEN_W-1:0];

    // Status to the controller
    always_comb begin
        o_stat.is_free   = (r_item.mode == MODE_FREE);
        o_stat.ignore    = (r_item.mode == MODE_FREE) ? (r_item.data_address == '0)
                                                      : (r_item.request_bytes == '0);
        o_stat.empty     = r_empty;
        o_stat.fit       = r_rd_free && (r_rd_len >= r_item.request_bytes);
        o_stat.split_ok  = (SUM_W'(r_rd_len) >= need_sum) && r_spare_ok
                           && (split_start < SUM_W'(ARENA_BYTES));
        o_stat.last      = (r_cur == r_tail) || (r_cnt == IW'(BLOCK_SLOTS - 1));
        o_stat.append_ok = r_spare_ok && (top_need <= SUM_W'(ARENA_BYTES));
        o_stat.match     = (data_sum == SUM_W'(r_item.data_address));
        o_stat.nx_free   = r_rd_free;
    end

    // Lowest spare slot, registered
    always_comb begin
        spare_idx = '0;
        spare_any = 1'b0;
        for (int i = BLOCK_SLOTS - 1; i >= 0; i--) begin
            if (!r_taken[i]) begin
                spare_idx = IW'(i);
                spare_any = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_spare    <= spare_idx;
        r_spare_ok <= spare_any;
    end

    // Table write port
    always_comb begin
        w_en_start = 1'b0;
        w_en_len   = 1'b0;
        w_en_free  = 1'b0;
        w_en_link  = 1'b0;
        w_addr     = r_cur;
        w_start    = split_start[ADDR_W-1:0];
        w_len      = r_rd_len - r_item.request_bytes - LEN_W'(r_hdr);
        w_free     = 1'b1;
        w_link     = r_rd_link;
        n_grant    = r_grant;
        case (i_cmd.op)
            OP_SPLIT_NEW: begin
                w_addr     = r_spare;
                w_en_start = 1'b1;
                w_en_len   = 1'b1;
                w_en_free  = 1'b1;
                w_en_link  = 1'b1;
                n_grant    = data_sum[ADDR_W-1:0];
            end
            OP_SPLIT_CUR: begin
                w_en_len  = 1'b1;
                w_en_free = 1'b1;
                w_en_link = 1'b1;
                w_len     = r_item.request_bytes;
                w_free    = 1'b0;
                w_link    = r_slot;
            end
            OP_ALLOC_CUR: begin
                w_en_free = 1'b1;
                w_free    = 1'b0;
                n_grant   = data_sum[ADDR_W-1:0];
            end
            OP_APPEND: begin
                w_addr     = r_spare;
                w_en_start = 1'b1;
                w_en_len   = 1'b1;
                w_en_free  = 1'b1;
                w_en_link  = 1'b1;
                w_start    = r_top[ADDR_W-1:0];
                w_len      = r_item.request_bytes;
                w_free     = 1'b0;
                w_link     = '0;
                n_grant    = r_top[ADDR_W-1:0] + ADDR_W'(r_hdr);
            end
            OP_LINK: begin
                w_addr    = r_aux;
                w_en_link = 1'b1;
                w_link    = r_slot;
            end
            OP_FREE_CUR: begin
                w_en_free = 1'b1;
            end
            OP_MERGE: begin
                w_en_len  = 1'b1;
                w_en_link = 1'b1;
                w_len     = merge_len;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en_start) m_start[w_addr] <= w_start;
        if (w_en_len)   m_len[w_addr]   <= w_len;
        if (w_en_free)  m_free[w_addr]  <= w_free;
        if (w_en_link)  m_link[w_addr]  <= w_link;
    end

    // Table read port: address is the entry to inspect next cycle
    assign rd_addr = (i_cmd.op == OP_ADVANCE || i_cmd.op == OP_FREE_CUR) ? r_rd_link
                                                                         : r_cur;

    always_ff @(posedge i_clk) begin
        r_rd_start <= m_start[rd_addr];
        r_rd_len   <= m_len[rd_addr];
        r_rd_free  <= m_free[rd_addr];
        r_rd_link  <= m_link[rd_addr];
    end

    // Walk and scratch registers
    always_ff @(posedge i_clk) begin
        r_grant <= n_grant;
        case (i_cmd.op)
            OP_LOAD: begin
                r_item <= i_item;
                r_cur  <= r_head;
                r_cnt  <= '0;
            end
            OP_ADVANCE: begin
                r_cur <= r_rd_link;
                r_cnt <= r_cnt + IW'(1);
            end
            OP_SPLIT_NEW: begin
                r_slot <= r_spare;
            end
            OP_APPEND: begin
                r_slot <= r_spare;
                r_aux  <= r_tail;
            end
            OP_FREE_CUR: begin
                r_cur_len <= r_rd_len;
                r_nx      <= r_rd_link;
            end
            default: begin
            end
        endcase
    end

    // List state and slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_top   <= '0;
        end else begin
            case (i_cmd.op)
                OP_SPLIT_NEW: begin
                    r_taken[r_spare] <= 1'b1;
                end
                OP_SPLIT_CUR: begin
                    if (r_tail == r_cur) r_tail <= r_slot;
                end
                OP_APPEND: begin
                    r_taken[r_spare] <= 1'b1;
                    r_top            <= top_need[TOP_W-1:0];
                    r_tail           <= r_spare;
                    if (r_empty) begin
                        r_head  <= r_spare;
                        r_empty <= 1'b0;
                    end
                end
                OP_MERGE: begin
                    r_taken[r_nx] <= 1'b0;
                    if (r_tail == r_nx) r_tail <= r_cur;
                end
                default: begin
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_we) begin
            r_res.status         <= i_cmd.res_status;
            r_res.result_address <= (i_cmd.res_status == ST_DONE && r_item.mode == MODE_ALLOC)
                                    ? n_grant : '0;
        end
    end

    assign o_result = r_res;

endmodule

// ===== src/first_fit_block_allocator_unit.sv =====
// Top level of the first-fit block allocator: controller plus datapath.
`timescale 1ns / 1ps
// First-fit allocator over a fixed arena. A request is taken when start is
// high and busy is low; one result word follows, shown for a single cycle
// with o_strobe, and the receiver cannot hold it off. A request walks at
// most BLOCK_SLOTS list entries, then may take split, append and link, or
// merge steps; the block table has one read and one write port, so the walk
// inspects one entry per cycle. Ignored requests go to the response without
// a walk. The header size is written through the configuration channel,
// which is always ready, and must only be changed while busy is low.
module first_fit_block_allocator_unit
    import ffba_pkg::*;
#(
    parameter int unsigned BLOCK_SLOTS = 32,
    parameter int unsigned ARENA_BYTES = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req_word        i_item,
    output logic             o_strobe,
    output t_res_word        o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [HDR_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    ffba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    ffba_dpath #(
        .BLOCK_SLOTS (BLOCK_SLOTS),
        .ARENA_BYTES (ARENA_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (o_result)
    );

    // A strobe only ends a request in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy) else $error("strobe without request in flight");

    // Accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request not taken");

    // One strobe per request
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("strobe held");

    // Failed requests carry a zero address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_DONE) |-> (o_result.result_address == '0))
        else $error("address on failed request");

endmodule
